FILE: design/tbuart_pkg.sv
// Shared types, constants and helpers of the timer-driven 8N1 UART.
`default_nettype none
package tbuart_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int BAUD_DIV_W  = 16;
	localparam int COUNT_W     = TIMER_WIDTH + 1;

	localparam logic [BAUD_DIV_W-1:0] BAUD_DIV_RESET = 16'd104;

	localparam logic [3:0] TX_FRAME_BITS = 4'd10;
	localparam logic [3:0] TX_START_LEFT = 4'd9;
	localparam logic [3:0] RX_DATA_BITS  = 4'd8;

	typedef logic [TIMER_WIDTH-1:0] period_t;
	typedef logic [COUNT_W-1:0]     count_t;

	typedef struct packed {
		logic       rx_line;
		logic       tx_load;
		logic [7:0] tx_byte;
	} in_t;

	typedef struct packed {
		logic       tx_line;
		logic       tx_busy;
		logic       rx_valid;
		logic [7:0] rx_byte;
	} out_t;

	typedef struct packed {
		logic line;
		logic busy;
	} tx_stat_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} rx_stat_t;

	// The bit period as seen by a timer of TIMER_WIDTH bits.
	function automatic period_t period_of(input logic [BAUD_DIV_W-1:0] bt);
		period_t p;
		for (int i = 0; i < TIMER_WIDTH; i++) begin
			p[i] = (i < BAUD_DIV_W) ? bt[i] : 1'b0;
		end
		return p;
	endfunction

endpackage
`default_nettype wire

FILE: design/tbuart_tx.sv
// Transmitter: free-running bit-period counter and frame shifter.
`default_nettype none
module tbuart_tx import tbuart_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic       load,
	input  wire logic [7:0] data,
	input  wire period_t    period,
	output tx_stat_t        stat_d
);

	period_t    phase_q;
	logic [3:0] bits_q;
	logic [7:0] shift_q;
	logic       level_q;

	period_t    phase_d;
	logic [3:0] bits_a, bits_d;
	logic [7:0] shift_a, shift_d;
	logic       level_d;
	logic [TIMER_WIDTH:0] phase_inc;

	always_comb begin
		bits_a  = bits_q;
		shift_a = shift_q;
		if (load && bits_q == 4'd0) begin
			bits_a  = TX_FRAME_BITS;
			shift_a = data;
		end
		bits_d  = bits_a;
		shift_d = shift_a;
		level_d = level_q;
		if (phase_q == '0 && bits_a != 4'd0) begin
			bits_d = bits_a - 4'd1;
			if (bits_d == TX_START_LEFT) begin
				level_d = 1'b0;
			end else if (bits_d == 4'd0) begin
				level_d = 1'b1;
			end else begin
				level_d = shift_a[0];
				shift_d = {1'b0, shift_a[7:1]};
			end
		end
		phase_inc = {1'b0, phase_q} + (TIMER_WIDTH+1)'(1);
		if (phase_inc >= {1'b0, period}) begin
			phase_d = '0;
		end else begin
			phase_d = phase_inc[TIMER_WIDTH-1:0];
		end
		stat_d.line = level_d;
		stat_d.busy = (bits_d != 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			bits_q  <= 4'd0;
			shift_q <= 8'd0;
			level_q <= 1'b1;
		end else if (step) begin
			phase_q <= phase_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			level_q <= level_d;
		end
	end

endmodule
`default_nettype wire

FILE: design/tbuart_rx.sv
// Receiver: falling-edge start, mid-bit sampling countdown and byte assembly.
`default_nettype none
module tbuart_rx import tbuart_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step,
	input  wire logic    line,
	input  wire period_t period,
	output rx_stat_t     stat_d
);

	logic       active_q, active_d;
	count_t     count_q, count_d;
	logic [3:0] idx_q, idx_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] held_q, held_d;
	logic       prev_q;
	logic       valid_d;

	always_comb begin
		active_d = active_q;
		count_d  = count_q;
		idx_d    = idx_q;
		shift_d  = shift_q;
		held_d   = held_q;
		valid_d  = 1'b0;
		if (active_q) begin
			if (count_q > COUNT_W'(1)) begin
				count_d = count_q - COUNT_W'(1);
			end else if (idx_q < RX_DATA_BITS) begin
				if (line) begin
					shift_d[idx_q[2:0]] = 1'b1;
				end
				idx_d   = idx_q + 4'd1;
				count_d = {1'b0, period};
			end else begin
				held_d   = shift_q;
				valid_d  = 1'b1;
				active_d = 1'b0;
				count_d  = '0;
				idx_d    = 4'd0;
			end
		end else if (prev_q && !line) begin
			// Wait one and a half bit periods to land in the middle of data bit 0.
			active_d = 1'b1;
			count_d  = {1'b0, period} + {2'b00, period[TIMER_WIDTH-1:1]};
			idx_d    = 4'd0;
			shift_d  = 8'd0;
		end
		stat_d.valid = valid_d;
		stat_d.data  = held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			count_q  <= '0;
			idx_q    <= 4'd0;
			shift_q  <= 8'd0;
			held_q   <= 8'd0;
			prev_q   <= 1'b1;
		end else if (step) begin
			active_q <= active_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			shift_q  <= shift_d;
			held_q   <= held_d;
			prev_q   <= line;
		end
	end

endmodule
`default_nettype wire

FILE: design/tbuart_oreg.sv
// Result register with one skid entry between the core and the output channel.
`default_nettype none
module tbuart_oreg import tbuart_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire out_t in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_t      out_data
);

	out_t main_q, skid_q;
	logic main_vld_q, skid_vld_q;
	logic acc, take;

	assign in_stall  = skid_vld_q;
	assign acc       = in_valid && !skid_vld_q;
	assign take      = main_vld_q && !out_stall;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (acc) begin
			if (main_vld_q && !take) begin
				skid_vld_q <= 1'b1;
			end else begin
				main_vld_q <= 1'b1;
			end
		end else if (take) begin
			main_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				main_q <= skid_q;
			end
		end else if (acc) begin
			if (main_vld_q && !take) begin
				skid_q <= in_data;
			end else begin
				main_q <= in_data;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/timer_based_uart_8n1.sv
// Timer-driven UART 8N1 transmitter and receiver top level.
// Each input transfer is one tick of the bit timer and yields exactly one result
// transfer. The block takes one tick per clock cycle while its input is not
// stalled: the transmit and receive state advance on each accepted tick, and the
// result is written into the result register, or into the skid entry of the
// two-entry output buffer while the result register is full and stalled. The
// input is stalled only while both buffer entries are full. The bit period
// register may be written only while no tick is in flight; the new period takes
// effect in the transmit phase compare and at the next receive countdown reload.
`default_nettype none
module timer_based_uart_8n1 import tbuart_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_t                   in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_t                       out_data,
	input  wire logic                  cfg_we,
	input  wire logic [BAUD_DIV_W-1:0] cfg_wdata
);

	logic [BAUD_DIV_W-1:0] baud_div_q;
	period_t               period;
	logic                  step;
	tx_stat_t              tx_stat;
	rx_stat_t              rx_stat;
	out_t                  res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_div_q <= BAUD_DIV_RESET;
		end else if (cfg_we) begin
			baud_div_q <= cfg_wdata;
		end
	end

	assign period = period_of(baud_div_q);
	assign step   = in_valid && !in_stall;

	tbuart_tx u_tx (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.load   (in_data.tx_load),
		.data   (in_data.tx_byte),
		.period (period),
		.stat_d (tx_stat)
	);

	tbuart_rx u_rx (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.line   (in_data.rx_line),
		.period (period),
		.stat_d (rx_stat)
	);

	always_comb begin
		res_d.tx_line  = tx_stat.line;
		res_d.tx_busy  = tx_stat.busy;
		res_d.rx_valid = rx_stat.valid;
		res_d.rx_byte  = rx_stat.data;
	end

	tbuart_oreg u_oreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (res_d),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

FILE: dv/timer_based_uart_8n1_test.sv
// Self-checking testbench of the timer-driven 8N1 UART with a tick-exact predictor.
module timer_based_uart_8n1_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tbuart_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 200;
	localparam int SETTLE_CYCLES  = 4;
	localparam int RANDOM_TICKS   = 1010;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;
	logic                  cfg_we;
	logic [BAUD_DIV_W-1:0] cfg_wdata;

	timer_based_uart_8n1 uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Predicted UART state.
	logic [BAUD_DIV_W-1:0] period_cfg = BAUD_DIV_RESET;
	int unsigned           ph_count   = 0;
	logic [3:0]            frame_left = '0;
	logic [7:0]            tx_sr      = '0;
	logic                  line_lvl   = 1'b1;
	logic                  rx_run     = 1'b0;
	int unsigned           rx_wait    = 0;
	logic [3:0]            rx_idx     = '0;
	logic [7:0]            rx_sr      = '0;
	logic [7:0]            rx_hold    = '0;
	logic                  rx_last    = 1'b1;

	out_t due_status[$];
	bit   rx_plan[$];
	out_t want;
	int   err_count   = 0;
	int   idle_cycles = 0;
	int   hold_left   = 0;
	int   stall_left  = 0;
	bit   source_gappy = 1'b0;
	bit   sink_gappy   = 1'b1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 92) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_t tick_of(input logic rx, input logic ld, input logic [7:0] b);
		in_t t;
		t.rx_line = rx;
		t.tx_load = ld;
		t.tx_byte = b;
		return t;
	endfunction

	// Advances the predicted UART by one timer tick and returns its predicted result.
	task automatic step_uart(input in_t t, output out_t r);
		int unsigned p;
		logic        got;
		p   = 32'(period_of(period_cfg));
		got = 1'b0;
		if (t.tx_load && frame_left == 0) begin
			frame_left = TX_FRAME_BITS;
			tx_sr      = t.tx_byte;
		end
		if (ph_count == 0 && frame_left != 0) begin
			frame_left = frame_left - 4'd1;
			if (frame_left == TX_START_LEFT) begin
				line_lvl = 1'b0;
			end else if (frame_left == 0) begin
				line_lvl = 1'b1;
			end else begin
				line_lvl = tx_sr[0];
				tx_sr    = tx_sr >> 1;
			end
		end
		ph_count = (ph_count + 1 >= p) ? 0 : ph_count + 1;

		if (rx_run) begin
			if (rx_wait > 1) begin
				rx_wait = rx_wait - 1;
			end else if (rx_idx < RX_DATA_BITS) begin
				if (t.rx_line) rx_sr[rx_idx[2:0]] = 1'b1;
				rx_idx  = rx_idx + 4'd1;
				rx_wait = p;
			end else begin
				rx_hold = rx_sr;
				got     = 1'b1;
				rx_run  = 1'b0;
				rx_wait = 0;
				rx_idx  = '0;
			end
		end else if (rx_last && !t.rx_line) begin
			// Falling edge while idle: the first sample lands mid-way through bit 0.
			rx_run  = 1'b1;
			rx_wait = (p * 3) >> 1;
			rx_idx  = '0;
			rx_sr   = '0;
		end
		rx_last = t.rx_line;

		r.tx_line  = line_lvl;
		r.tx_busy  = (frame_left != 0);
		r.rx_valid = got;
		r.rx_byte  = rx_hold;
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		err_count++;
	endtask

	task automatic send_tick(input in_t t, input int gap);
		out_t r;
		in_valid <= 1'b1;
		in_data  <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		step_uart(t, r);
		due_status.push_back(r);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_status.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_period(input logic [BAUD_DIV_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		period_cfg = v;
		cfg_we    <= 1'b0;
	endtask

	// Queues receive-line levels: mostly clean frames at the current period, some noise,
	// and some frames cut short.
	task automatic plan_line();
		int         bl, kind, k, len;
		logic [7:0] d;
		logic       lvl;
		bl   = (period_cfg < 1) ? 1 : int'(period_cfg);
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			repeat ($urandom_range(1, 2 * bl)) rx_plan.push_back(1'b1);
			d = 8'($urandom);
			for (k = 0; k < 10; k++) begin
				len = bl;
				if ($urandom_range(0, 9) == 0) len = bl + $urandom_range(0, 2) - 1;
				if (len < 1) len = 1;
				lvl = (k == 0) ? 1'b0 : (k == 9) ? 1'b1 : d[k-1];
				repeat (len) rx_plan.push_back(lvl);
			end
		end else if (kind < 90) begin
			repeat ($urandom_range(1, 3 * bl)) rx_plan.push_back(1'($urandom_range(0, 1)));
		end else begin
			repeat (bl) rx_plan.push_back(1'b0);
			repeat ($urandom_range(1, 5)) begin
				lvl = 1'($urandom_range(0, 1));
				repeat (bl) rx_plan.push_back(lvl);
			end
			repeat (bl) rx_plan.push_back(1'b1);
		end
	endtask

	task automatic run_ticks(input int n, input int load_pct);
		in_t t;
		int  i, gap;
		for (i = 0; i < n; i++) begin
			if (rx_plan.size() == 0) plan_line();
			t.rx_line = rx_plan.pop_front();
			t.tx_load = ($urandom_range(0, 99) < load_pct);
			t.tx_byte = 8'($urandom);
			gap = (source_gappy && $urandom_range(0, 99) >= 70) ? pick_gap() : 0;
			send_tick(t, gap);
		end
	endtask

	// Reset period: the first tick is a boundary, and a second load while busy is dropped.
	task automatic test_first_tick();
		send_tick(tick_of(1'b1, 1'b1, 8'hA5), 0);
		send_tick(tick_of(1'b1, 1'b1, 8'h5A), 0);
		send_tick(tick_of(1'b1, 1'b0, 8'h00), 0);
	endtask

	// Periods of zero and one: every tick is a boundary and every receive wait is one tick.
	// The tick that completes a byte also sees a falling edge, which must not start a frame.
	task automatic test_shortest_periods();
		logic [11:0] seq0;
		logic [9:0]  seq1;
		int          i;
		seq0 = 12'h99A;
		seq1 = 10'h2D4;
		write_period(16'h0000);
		for (i = 0; i < 12; i++) send_tick(tick_of(seq0[i], i == 11, 8'hFF), 0);
		write_period(16'h0001);
		for (i = 0; i < 10; i++) send_tick(tick_of(seq1[i], i == 0, 8'h00), 0);
	endtask

	task automatic test_longest_period();
		write_period(16'hFFFF);
		send_tick(tick_of(1'b1, 1'b1, 8'hFF), 0);
		send_tick(tick_of(1'b1, 1'b0, 8'h00), 0);
	endtask

	task automatic test_random_traffic();
		int done_ticks, n, pick;
		done_ticks = 0;
		while (done_ticks < RANDOM_TICKS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) write_period(16'($urandom_range(0, 1)));
			else if (pick < 5) write_period(16'($urandom_range(2, 6)));
			else write_period(16'($urandom_range(7, 24)));
			source_gappy = ($urandom_range(0, 3) != 0);
			sink_gappy   = ($urandom_range(0, 3) != 0);
			n = $urandom_range(100, 250);
			if (n > RANDOM_TICKS - done_ticks) n = RANDOM_TICKS - done_ticks;
			run_ticks(n, 10);
			done_ticks += n;
		end
	endtask

	// The sink holds off for a long stretch while ticks keep coming, so the block
	// must fill up and stall its input; then the source waits for every result.
	task automatic test_backpressure();
		write_period(16'd4);
		source_gappy = 1'b0;
		sink_gappy   = 1'b0;
		hold_left    = LONG_HOLD;
		run_ticks(60, 10);
		drain();
		sink_gappy = 1'b1;
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (sink_gappy && $urandom_range(0, 99) < 20) stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_status.size() == 0) begin
				report_mismatch("result transfer with no tick waiting");
			end else begin
				want = due_status.pop_front();
				if (out_data.tx_line !== want.tx_line)
					report_mismatch($sformatf("tx_line got %0b want %0b",
						out_data.tx_line, want.tx_line));
				if (out_data.tx_busy !== want.tx_busy)
					report_mismatch($sformatf("tx_busy got %0b want %0b",
						out_data.tx_busy, want.tx_busy));
				if (out_data.rx_valid !== want.rx_valid)
					report_mismatch($sformatf("rx_valid got %0b want %0b",
						out_data.rx_valid, want.rx_valid));
				if (out_data.rx_byte !== want.rx_byte)
					report_mismatch($sformatf("rx_byte got %02h want %02h",
						out_data.rx_byte, want.rx_byte));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timer_based_uart_8n1_test: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_tick();
		test_shortest_periods();
		test_longest_period();
		test_backpressure();
		test_random_traffic();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("timer_based_uart_8n1_test: done, clean");
		end else begin
			$display("timer_based_uart_8n1_test: done, errors");
		end
		$finish;
	end

endmodule
